FILE: src/dtc_pkg.sv
package dtc_pkg;

   // field widths
   localparam int SAMPLE_W   = 10;
   localparam int SETPOINT_W = 10;
   localparam int CODE_W     = 8;
   localparam int CTRL_W     = 32;
   localparam int ERR_W      = 17;
   localparam int ERRSUM_W   = 40;   // |errsum| < 2^38
   localparam int FRAC_BITS  = 16;

   localparam int DTC_OUTPUT_WIDTH = 32;

   localparam int SETPOINT_RESET  = 60;
   localparam int SETPOINT_OFFSET = 20;

   // Q16 coefficients
   localparam int C_E0 = 1456210;
   localparam int C_E1 = 1805713;
   localparam int C_E2 = 459801;
   localparam int C_U1 = 21103;
   localparam int C_U2 = 44433;

   // drive byte: round(u/48) clamped to 0..255
   localparam int CODE_MAX       = 255;
   localparam int DIV_STEP       = 48;
   localparam int DIV_BIAS       = DIV_STEP / 2;
   localparam int CODE_SAT_LIMIT = (CODE_MAX + 1) * DIV_STEP - DIV_BIAS;
   localparam int RECIP_3        = 683;   // floor(x/3) = (x*683)>>11 for x < 2048
   localparam int RECIP_SHIFT    = 11;

   typedef logic        [SAMPLE_W-1:0]   sample_type;
   typedef logic        [SETPOINT_W-1:0] setpoint_type;
   typedef logic        [CODE_W-1:0]     code_type;
   typedef logic signed [CTRL_W-1:0]     ctrl_type;
   typedef logic signed [ERR_W-1:0]      err_type;
   typedef logic signed [ERRSUM_W-1:0]   errsum_type;

endpackage

FILE: src/dtc_req_if.sv
interface dtc_req_if;
   import dtc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

FILE: src/dtc_rsp_if.sv
interface dtc_rsp_if;
   import dtc_pkg::*;

   logic     valid;
   logic     ready;
   code_type dac_code;
   ctrl_type control_value;

   modport source (output valid, output dac_code, output control_value, input ready);
   modport sink   (input valid, input dac_code, input control_value, output ready);
endinterface

FILE: src/dtc_csr_if.sv
interface dtc_csr_if;
   import dtc_pkg::*;

   logic         valid;
   logic         ready;
   setpoint_type setpoint_temp;

   modport source (output valid, output setpoint_temp, input ready);
   modport sink   (input valid, input setpoint_temp, output ready);
endinterface

FILE: src/dtc_err_stage.sv
module dtc_err_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  dtc_pkg::setpoint_type setpoint,
   input  logic                  in_valid,
   input  dtc_pkg::sample_type   adc_sample,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dtc_pkg::errsum_type   errsum
);
   import dtc_pkg::*;

   localparam errsum_type C_E0_S = ERRSUM_W'(C_E0);
   localparam errsum_type C_E1_S = ERRSUM_W'(C_E1);
   localparam errsum_type C_E2_S = ERRSUM_W'(C_E2);
   localparam logic signed [ERR_W:0] OFFSET_S = (ERR_W + 1)'(SETPOINT_OFFSET * 64);

   logic               valid_ff, valid_in;
   logic               load;
   err_type            e1_ff, e2_ff, e1_in, e2_in;
   errsum_type         errsum_ff, errsum_in;
   logic [12:0]        sample_x5;
   logic signed [ERR_W:0] e_wide;
   err_type            e_cur;

   always_comb begin
      in_ready  = !valid_ff || out_ready;
      load      = in_valid && in_ready;
      valid_in  = load || (valid_ff && !out_ready);

      // error in volts*1024: (sp - 20)*64 - sample*5
      sample_x5 = {1'b0, adc_sample, 2'b00} + {3'b000, adc_sample};
      e_wide    = $signed({2'b00, setpoint, 6'b000000}) - OFFSET_S
                - $signed({5'b00000, sample_x5});
      e_cur     = e_wide[ERR_W-1:0];

      errsum_in = errsum_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      if (load) begin
         errsum_in = ERRSUM_W'(e_cur) * C_E0_S - ERRSUM_W'(e1_ff) * C_E1_S
                   + ERRSUM_W'(e2_ff) * C_E2_S;
         e1_in     = e_cur;
         e2_in     = e1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         e1_ff    <= '0;
         e2_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
      end
      errsum_ff <= errsum_in;
   end

   assign out_valid = valid_ff;
   assign errsum    = errsum_ff;

endmodule

FILE: src/dtc_out_stage.sv
module dtc_out_stage #(
   parameter int OUTPUT_WIDTH = dtc_pkg::DTC_OUTPUT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  dtc_pkg::errsum_type            errsum,
   output logic                           in_ready,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [OUTPUT_WIDTH-1:0] u_value
);
   import dtc_pkg::*;

   localparam int SUM_W = OUTPUT_WIDTH + FRAC_BITS + 2;
   localparam int Q_W   = SUM_W - FRAC_BITS;

   localparam logic signed [SUM_W-1:0] C_U1_S  = SUM_W'(C_U1);
   localparam logic signed [SUM_W-1:0] C_U2_S  = SUM_W'(C_U2);
   localparam logic signed [SUM_W-1:0] ROUND_S = SUM_W'(1 << (FRAC_BITS - 1));

   logic                           valid_ff, valid_in;
   logic                           load;
   logic signed [OUTPUT_WIDTH-1:0] u1_ff, u2_ff, u1_in, u2_in;
   logic signed [OUTPUT_WIDTH-1:0] u_ff, u_in, u_sat;
   logic signed [SUM_W-1:0]        sum;
   logic signed [Q_W-1:0]          q;
   logic [Q_W-OUTPUT_WIDTH:0]      q_top;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = load || (valid_ff && !out_ready);

      // exact Q16 sum, rounded half up
      sum   = SUM_W'(errsum) + SUM_W'(u1_ff) * C_U1_S + SUM_W'(u2_ff) * C_U2_S + ROUND_S;
      q     = sum[SUM_W-1:FRAC_BITS];
      q_top = q[Q_W-1:OUTPUT_WIDTH-1];

      priority if ((&q_top) || !(|q_top)) begin
         u_sat = q[OUTPUT_WIDTH-1:0];
      end else if (q[Q_W-1]) begin
         u_sat = {1'b1, {(OUTPUT_WIDTH-1){1'b0}}};
      end else begin
         u_sat = {1'b0, {(OUTPUT_WIDTH-1){1'b1}}};
      end

      u_in  = u_ff;
      u1_in = u1_ff;
      u2_in = u2_ff;
      if (load) begin
         u_in  = u_sat;
         u1_in = u_sat;
         u2_in = u1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         u1_ff    <= '0;
         u2_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         u1_ff    <= u1_in;
         u2_ff    <= u2_in;
      end
      u_ff <= u_in;
   end

   assign out_valid = valid_ff;
   assign u_value   = u_ff;

endmodule

FILE: src/dtc_code_stage.sv
module dtc_code_stage #(
   parameter int OUTPUT_WIDTH = dtc_pkg::DTC_OUTPUT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [OUTPUT_WIDTH-1:0] u_value,
   output logic                           in_ready,
   output logic                           out_valid,
   input  logic                           out_ready,
   output dtc_pkg::code_type              dac_code,
   output dtc_pkg::ctrl_type              control_value
);
   import dtc_pkg::*;

   localparam logic signed [OUTPUT_WIDTH-1:0] SAT_S = OUTPUT_WIDTH'(CODE_SAT_LIMIT);

   logic        valid_ff, valid_in;
   logic        load;
   code_type    code_ff, code_in, code_next;
   ctrl_type    ctrl_ff, ctrl_in;
   logic [13:0] biased;
   logic [9:0]  by16;
   logic [19:0] prod;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = load || (valid_ff && !out_ready);

      // (u + 24) / 48 as ((u + 24) >> 4) / 3, only used for 0 < u < limit
      biased = u_value[13:0] + 14'(DIV_BIAS);
      by16   = biased[13:4];
      prod   = 20'(by16) * 20'(RECIP_3);

      priority if (u_value[OUTPUT_WIDTH-1] || !(|u_value)) begin
         code_next = '0;
      end else if (u_value >= SAT_S) begin
         code_next = CODE_W'(CODE_MAX);
      end else begin
         code_next = prod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];
      end

      code_in = code_ff;
      ctrl_in = ctrl_ff;
      if (load) begin
         code_in = code_next;
         ctrl_in = CTRL_W'(u_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      ctrl_ff <= ctrl_in;
   end

   assign out_valid     = valid_ff;
   assign dac_code      = code_ff;
   assign control_value = ctrl_ff;

endmodule

FILE: src/deadbeat_temperature_controller.sv
// Deadbeat temperature controller.
// req_bus carries one 10-bit converter sample per transfer; rsp_bus returns one
// result per sample: the drive byte round(u/48) clamped to 0..255, and the
// saturated controller output u in volts*1024. csr_bus writes the setpoint
// (degrees); it is always ready, and the user must see that it is written only while
// the pipeline is empty; the block itself does not enforce this. Each sample is
// registered in turn by the error stage, output recurrence stage and drive byte stage.
// Throughput: one sample per cycle while rsp_bus accepts results. The output
// recurrence stage closes its loop through the two stored outputs; this sets the rate.
// Reset clears the pipeline, zeroes the stored errors and outputs, and loads the
// setpoint with 60.
// When the receiver stalls, each stage holds its item; req_bus.ready falls once
// all three stages are occupied and rises again as soon as rsp_bus moves.
module deadbeat_temperature_controller #(
   parameter int OUTPUT_WIDTH = dtc_pkg::DTC_OUTPUT_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   dtc_req_if.sink   req_bus,
   dtc_rsp_if.source rsp_bus,
   dtc_csr_if.sink   csr_bus
);
   import dtc_pkg::*;

   setpoint_type                   setpoint_ff, setpoint_in;
   logic                           err_valid, err_ready;
   errsum_type                     errsum;
   logic                           u_valid, u_ready;
   logic signed [OUTPUT_WIDTH-1:0] u_value;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      setpoint_in = setpoint_ff;
      if (csr_bus.valid) begin
         setpoint_in = csr_bus.setpoint_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_W'(SETPOINT_RESET);
      end else begin
         setpoint_ff <= setpoint_in;
      end
   end

   dtc_err_stage u_err (
      .clock      (clock),
      .reset      (reset),
      .setpoint   (setpoint_ff),
      .in_valid   (req_bus.valid),
      .adc_sample (req_bus.adc_sample),
      .in_ready   (req_bus.ready),
      .out_valid  (err_valid),
      .out_ready  (err_ready),
      .errsum     (errsum)
   );

   dtc_out_stage #(
      .OUTPUT_WIDTH (OUTPUT_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (err_valid),
      .errsum    (errsum),
      .in_ready  (err_ready),
      .out_valid (u_valid),
      .out_ready (u_ready),
      .u_value   (u_value)
   );

   dtc_code_stage #(
      .OUTPUT_WIDTH (OUTPUT_WIDTH)
   ) u_code (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (u_valid),
      .u_value       (u_value),
      .in_ready      (u_ready),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .dac_code      (rsp_bus.dac_code),
      .control_value (rsp_bus.control_value)
   );

endmodule
